// ----- rtl/sli_pkg.sv -----
package sli_pkg;

	// List bound and derived widths
	localparam int CAPACITY = 16;
	localparam int CNT_W    = 7;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VAL_W    = 32;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 3;
	localparam int OUT_W    = 48;
	localparam int OUT_PAD  = OUT_W - VAL_W - 2 * CNT_W;

	// Request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DELETED  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4,
		ST_DUMP     = 3'd5
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic produce;
		logic start_dump;
		logic dump_end;
	} stat_t;

endpackage

// ----- rtl/sorted_list_insert_delete.sv -----
// Sorted list insert/delete: CAPACITY register cells kept in ascending order.
// Insert and delete requests are taken back to back while the result register is free;
// the compare-and-shift cell chain is combinational. Results are registered and appear
// in the cycle after acceptance. Dump emits one entry per cycle while the receiver takes
// them, from the cell read mux, and holds the input off until the last entry is loaded.
// Reset (arst_n low, asynchronous) empties the list; no clearing pass is needed.
module sorted_list_insert_delete (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] item_value, [38:32] position, [45:39] count
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast    // last
);

	sli_pkg::cmd_t  cmd;
	sli_pkg::stat_t st;

	logic signed [sli_pkg::VAL_W-1:0] out_value;
	logic [sli_pkg::CNT_W-1:0]        out_pos;
	logic [sli_pkg::CNT_W-1:0]        out_cnt;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.st        (st),
		.cmd       (cmd)
	);

	sli_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (s_tuser),
		.value      (s_tdata),
		.cmd        (cmd),
		.st         (st),
		.out_status (m_tuser),
		.out_value  (out_value),
		.out_pos    (out_pos),
		.out_cnt    (out_cnt),
		.out_last   (m_tlast)
	);

	// Pack result fields, lowest first
	assign m_tdata = {{sli_pkg::OUT_PAD{1'b0}}, out_cnt, out_pos, out_value};

endmodule

// ----- rtl/sli_ctrl.sv -----
module sli_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sli_pkg::stat_t st,
	output sli_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   out_free;
	logic   load;

	// Output register is free when empty or being drained this cycle
	assign out_free   = !valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE) && out_free;
	assign cmd.accept = in_valid && in_ready;
	assign cmd.step   = (state_q == S_DUMP) && out_free;
	assign load       = (cmd.accept && st.produce) || cmd.step;
	assign out_valid  = valid_q;

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && st.start_dump)
						state_q <= S_DUMP;
				end
				S_DUMP: begin
					if (cmd.step && st.dump_end)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/sli_datapath.sv -----
module sli_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sli_pkg::MODE_W-1:0]  mode,
	input  logic signed [sli_pkg::VAL_W-1:0] value,
	input  sli_pkg::cmd_t               cmd,
	output sli_pkg::stat_t              st,
	output logic [sli_pkg::STAT_W-1:0]  out_status,
	output logic signed [sli_pkg::VAL_W-1:0] out_value,
	output logic [sli_pkg::CNT_W-1:0]   out_pos,
	output logic [sli_pkg::CNT_W-1:0]   out_cnt,
	output logic                        out_last
);

	localparam int CAP   = sli_pkg::CAPACITY;
	localparam int CNT_W = sli_pkg::CNT_W;
	localparam int IDX_W = sli_pkg::IDX_W;
	localparam int VAL_W = sli_pkg::VAL_W;

	logic signed [VAL_W-1:0] cell_q [CAP];
	logic signed [VAL_W-1:0] ins_next [CAP];
	logic signed [VAL_W-1:0] del_next [CAP];
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        idx_inc;
	logic [CNT_W-1:0]        del_pos;
	logic [CAP-1:0]          lt;
	logic [CAP-1:0]          eq;
	logic [CAP-1:0]          hit;
	logic                    full;
	logic                    empty;
	logic                    any_eq;
	logic                    wr_ins;
	logic                    wr_del;

	logic [sli_pkg::STAT_W-1:0] stat_q;
	logic signed [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]           pos_q;
	logic [CNT_W-1:0]           ocnt_q;
	logic                       last_q;

	assign full    = (cnt_q == CNT_W'(CAP));
	assign empty   = (cnt_q == '0);
	assign any_eq  = |eq;
	assign idx_inc = idx_q + CNT_W'(1);

	// Per-cell compare against the request value
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			lt[i] = (CNT_W'(i) < cnt_q) && (cell_q[i] < value);
			eq[i] = (CNT_W'(i) < cnt_q) && (cell_q[i] == value);
		end
	end

	// First match: prefix flags and 1-based position
	always_comb begin
		logic seen;
		seen    = 1'b0;
		del_pos = '0;
		for (int i = 0; i < CAP; i++) begin
			seen   = seen | eq[i];
			hit[i] = seen;
		end
		for (int i = CAP - 1; i >= 0; i--) begin
			if (eq[i])
				del_pos = CNT_W'(i + 1);
		end
	end

	// Shifted cell images for insert and delete
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			if (lt[i])
				ins_next[i] = cell_q[i];
			else if (i == 0)
				ins_next[i] = value;
			else if (lt[(i == 0) ? 0 : i - 1])
				ins_next[i] = value;
			else
				ins_next[i] = cell_q[(i == 0) ? 0 : i - 1];
			if (hit[i] && (i < CAP - 1))
				del_next[i] = cell_q[(i < CAP - 1) ? i + 1 : i];
			else
				del_next[i] = cell_q[i];
		end
	end

	assign wr_ins = cmd.accept && (mode == sli_pkg::MODE_INSERT) && !full;
	assign wr_del = cmd.accept && (mode == sli_pkg::MODE_DELETE) && !empty && any_eq;

	// Status toward the controller
	assign st.produce    = (mode == sli_pkg::MODE_INSERT) || (mode == sli_pkg::MODE_DELETE)
	                       || (mode == sli_pkg::MODE_DUMP);
	assign st.start_dump = (mode == sli_pkg::MODE_DUMP) && (cnt_q > CNT_W'(1));
	assign st.dump_end   = (idx_inc == cnt_q);

	// Cell chain
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAP; i++) begin
			if (wr_ins)
				cell_q[i] <= ins_next[i];
			else if (wr_del)
				cell_q[i] <= del_next[i];
		end
	end

	// Occupancy and dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (wr_ins)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (wr_del)
				cnt_q <= cnt_q - CNT_W'(1);
			if (cmd.accept)
				idx_q <= CNT_W'(1);
			else if (cmd.step)
				idx_q <= idx_inc;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			stat_q <= sli_pkg::ST_DUMP;
			val_q  <= cell_q[idx_q[IDX_W-1:0]];
			pos_q  <= idx_inc;
			ocnt_q <= cnt_q;
			last_q <= (idx_inc == cnt_q);
		end else if (cmd.accept) begin
			val_q  <= value;
			pos_q  <= '0;
			ocnt_q <= cnt_q;
			last_q <= 1'b1;
			case (mode)
				sli_pkg::MODE_INSERT: begin
					if (full) begin
						stat_q <= sli_pkg::ST_FULL;
					end else begin
						stat_q <= sli_pkg::ST_INSERTED;
						ocnt_q <= cnt_q + CNT_W'(1);
					end
				end
				sli_pkg::MODE_DELETE: begin
					if (empty) begin
						stat_q <= sli_pkg::ST_EMPTY;
					end else if (!any_eq) begin
						stat_q <= sli_pkg::ST_NOTFOUND;
					end else begin
						stat_q <= sli_pkg::ST_DELETED;
						pos_q  <= del_pos;
						ocnt_q <= cnt_q - CNT_W'(1);
					end
				end
				sli_pkg::MODE_DUMP: begin
					if (empty) begin
						stat_q <= sli_pkg::ST_EMPTY;
					end else begin
						stat_q <= sli_pkg::ST_DUMP;
						val_q  <= cell_q[0];
						pos_q  <= CNT_W'(1);
						last_q <= (cnt_q == CNT_W'(1));
					end
				end
				default: stat_q <= stat_q;
			endcase
		end
	end

	assign out_status = stat_q;
	assign out_value  = val_q;
	assign out_pos    = pos_q;
	assign out_cnt    = ocnt_q;
	assign out_last   = last_q;

endmodule

// ----- bench/sorted_list_insert_delete_test.sv -----
`timescale 1ns / 1ps

import sli_pkg::*;

// One result as seen on the master side
typedef struct packed {
	status_t     status;
	logic [31:0] item_value;
	logic [6:0]  position;
	logic [6:0]  count;
	logic        last;
} list_result_t;

// Tracks the sorted list contents and the results still owed by the block
class sorted_list_scoreboard;
	logic signed [31:0] held_values[$];
	list_result_t       expected_results[$];
	int                 errors;

	function new();
		errors = 0;
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	function void expect_result(status_t st, logic [31:0] v, int pos, int cnt, bit last);
		list_result_t r;
		r.status     = st;
		r.item_value = v;
		r.position   = 7'(pos);
		r.count      = 7'(cnt);
		r.last       = last;
		expected_results.push_back(r);
	endfunction

	// Apply one accepted request to the list and queue the results it causes
	function void predict_request(logic [1:0] mode, logic signed [31:0] value);
		int n;
		int slot;
		n = held_values.size();
		slot = 0;
		case (mode)
			MODE_INSERT: begin
				if (n >= CAPACITY) begin
					expect_result(ST_FULL, value, 0, n, 1'b1);
				end else begin
					// equal values go ahead of stored ones
					while (slot < n && held_values[slot] < value)
						slot++;
					held_values.insert(slot, value);
					expect_result(ST_INSERTED, value, 0, n + 1, 1'b1);
				end
			end
			MODE_DELETE: begin
				if (n == 0) begin
					expect_result(ST_EMPTY, value, 0, 0, 1'b1);
				end else begin
					while (slot < n && held_values[slot] != value)
						slot++;
					if (slot == n) begin
						expect_result(ST_NOTFOUND, value, 0, n, 1'b1);
					end else begin
						held_values.delete(slot);
						expect_result(ST_DELETED, value, slot + 1, n - 1, 1'b1);
					end
				end
			end
			MODE_DUMP: begin
				if (n == 0) begin
					expect_result(ST_EMPTY, value, 0, 0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						expect_result(ST_DUMP, held_values[i], i + 1, n, i == n - 1);
				end
			end
			default: ;	// unused mode: no state change, no result
		endcase
	endfunction

	task report_mismatch(string msg);
		errors++;
		if (errors <= 50)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task check_result(list_result_t got);
		list_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result status %0d value %h",
				got.status, got.item_value));
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d",
					got.status, want.status));
			if (got.item_value !== want.item_value)
				report_mismatch($sformatf("item_value got %h want %h",
					got.item_value, want.item_value));
			if (got.position !== want.position)
				report_mismatch($sformatf("position got %0d want %0d",
					got.position, want.position));
			if (got.count !== want.count)
				report_mismatch($sformatf("count got %0d want %0d",
					got.count, want.count));
			if (got.last !== want.last)
				report_mismatch($sformatf("last got %b want %b", got.last, want.last));
		end
	endtask
endclass

module sorted_list_insert_delete_test;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS     = 200;
	localparam int PHASE_LEN           = 50;
	localparam int HOLD_CYCLES         = 150;
	localparam int WATCHDOG_LIMIT      = 3000;
	localparam int DRAIN_CYCLES        = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	int quiet_cycles = 0;

	sorted_list_scoreboard sb = new();

	sorted_list_insert_delete dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Handshake monitor, checker and watchdog
	always @(posedge clk) begin
		list_result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.predict_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				got.status     = status_t'(m_tuser);
				got.item_value = m_tdata[31:0];
				got.position   = m_tdata[38:32];
				got.count      = m_tdata[45:39];
				got.last       = m_tlast;
				sb.check_result(got);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offer one request and hold it until accepted, then maybe go idle
	task send_request(input logic [1:0] mode, input logic [31:0] value);
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop offering until every owed result has come back
	task wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly small values so that duplicates and hits on delete are common
	function logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = 32'($urandom_range(16)) - 32'd8;
			5: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0000_0000;
					default: v = 32'hffff_ffff;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		int sent;
		int ins_pct;
		int r;
		int n;
		logic [1:0] mode;
		logic [31:0] value;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, unused mode, extremes, duplicates, not found
		send_request(MODE_DELETE, 32'd5);
		send_request(MODE_DUMP, 32'h7fff_ffff);
		send_request(MODE_UNUSED, 32'hdead_beef);
		send_request(MODE_INSERT, 32'h8000_0000);
		send_request(MODE_INSERT, 32'h7fff_ffff);
		send_request(MODE_INSERT, 32'h0000_0000);
		send_request(MODE_INSERT, 32'hffff_ffff);
		send_request(MODE_INSERT, 32'h0000_0000);
		send_request(MODE_DUMP, 32'h0);
		send_request(MODE_DELETE, 32'd5);
		send_request(MODE_DELETE, 32'h0000_0000);
		send_request(MODE_DELETE, 32'h8000_0000);
		send_request(MODE_DELETE, 32'h7fff_ffff);
		// fill to capacity, then one refused insert
		for (int i = 0; i < CAPACITY - 2; i++)
			send_request(MODE_INSERT, 32'(i * 3 - 20));
		send_request(MODE_INSERT, 32'd99);
		send_request(MODE_DUMP, 32'h0);

		// Random requests over the idle/stall phases
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			if (sent % PHASE_LEN == 0) begin
				wait_drained();
				case (sent / PHASE_LEN)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 46; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 46; end
					default: begin idle_pct = 35; stall_pct = 35; end
				endcase
			end

			n = sb.held_values.size();
			ins_pct = (n < CAPACITY / 2) ? 60 : 40;
			r = $urandom_range(99);
			value = pick_value();
			if (r < ins_pct) begin
				mode = MODE_INSERT;
			end else if (r < 85) begin
				mode = MODE_DELETE;
				if (n > 0 && $urandom_range(99) < 65)
					value = sb.held_values[$urandom_range(n - 1)];
			end else if (r < 96) begin
				mode = MODE_DUMP;
			end else begin
				mode = MODE_UNUSED;
			end
			send_request(mode, value);
			if (mode != MODE_UNUSED) begin
				sent++;
				// one long receiver hold-off while requests keep coming
				if (sent == 15)
					hold_req <= 1'b1;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_datapath.sv
rtl/sorted_list_insert_delete.sv
bench/sorted_list_insert_delete_test.sv
